// File: src/rrts_pkg.sv
// Shared constants, types and helpers for the round-robin task scheduler.
package rrts_pkg;

    localparam int NUM_SLOTS = 32;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int TIME_BITS = 32;
    localparam int STACK_W   = 10;
    localparam int OUT_SLOT_W = 5;

    localparam int OPCODE_W   = 3;
    localparam int DURATION_W = 16;
    localparam int NOW_W      = 32;
    localparam int STATUS_W   = 2;
    localparam int MODE_W     = 2;

    localparam int S_DATA_BITS = OPCODE_W + DURATION_W + NOW_W;
    localparam int S_DATA_W    = ((S_DATA_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS = OUT_SLOT_W + STATUS_W + OUT_SLOT_W;
    localparam int M_DATA_W    = ((M_DATA_BITS + 7) / 8) * 8;

    localparam logic [STACK_W-1:0] STACK_SIZE_RESET = STACK_W'(20);
    localparam int FORK_MEM_LIMIT = 1024;
    localparam int FORK_PROD_W    = STACK_W + SLOT_W + 1;

    localparam logic [OPCODE_W-1:0] OP_INIT     = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_TICK     = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_EXIT     = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_SLEEP    = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_SPAWN    = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_FORK     = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_WAKE_ALL = 3'd6;

    localparam logic [MODE_W-1:0] MODE_EMPTY = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SLEEP = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE_READY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FORK_REFUSED = 2'd2;

    typedef logic [SLOT_W-1:0]    slot_t;
    typedef logic [TIME_BITS-1:0] time_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_WAKE,
        ST_DONE
    } state_t;

    function automatic slot_t next_slot(input slot_t s);
        slot_t r;
        if (s == SLOT_W'(NUM_SLOTS - 1))
            r = '0;
        else
            r = s + SLOT_W'(1);
        return r;
    endfunction

    function automatic logic [OUT_SLOT_W-1:0] out_slot(input slot_t s);
        logic [SLOT_W+OUT_SLOT_W-1:0] wide;
        wide = {{OUT_SLOT_W{1'b0}}, s};
        return wide[OUT_SLOT_W-1:0];
    endfunction

endpackage

// File: src/round_robin_task_scheduler.sv
// Top level of the round-robin task scheduler with sleep timers.
//
// Input words arrive on s_tvalid/s_tready/s_tdata, one event each; every
// event yields exactly one result word on m_tvalid/m_tready/m_tdata.
// Slot modes and wake deadlines live in two synchronous RAMs (registered
// read); a valid flag per slot makes never-written slots read as empty.
// Init, exit, sleep, spawn, fork and unused opcodes go straight from idle
// to the done state; wake all first sweeps every slot through the mode RAM
// read port; a schedule tick reads one slot per cycle and stops at the
// first ready slot or expired sleeping slot, after at most NUM_SLOTS slots.
// The done state loads the result once the output register is free. One
// event is in work at a time; s_tready rises together with m_tvalid when
// the result is loaded. s_tready is high whenever no event is
// in work, also while a finished result waits in the output register. A
// stalled receiver holds the result and blocks only the completion of the
// following event. Reset empties every slot, zeroes the active slot and
// loads stack_size with 20; no clearing pass is run.
// cfg_wr_en writes stack_size at once; the user must use it only while idle, the block does not enforce this.
module round_robin_task_scheduler
    import rrts_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [STACK_W-1:0]  cfg_wr_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    // [2:0] opcode, [18:3] sleep_duration, [50:19] now_time, [55:51] zero
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // [4:0] running_slot, [6:5] status, [11:7] created_slot, [15:12] zero
    output logic [M_DATA_W-1:0] m_tdata
);

    state_t state_reg, state_next;

    logic [STACK_W-1:0]  stack_size_reg;
    slot_t               active_reg, active_next;
    slot_t               eval_slot_reg, eval_slot_next;
    slot_t               eval_cnt_reg, eval_cnt_next;
    time_t               now_reg, now_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    slot_t               created_reg, created_next;
    logic [NUM_SLOTS-1:0] mode_valid_reg;

    logic                m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    logic [OPCODE_W-1:0]   in_opcode;
    logic [DURATION_W-1:0] in_duration;
    logic [NOW_W-1:0]      in_now;
    time_t                 in_now_t;

    logic               mode_wr_en;
    slot_t              mode_wr_addr;
    logic [MODE_W-1:0]  mode_wr_data;
    logic [MODE_W-1:0]  mode_rd_data;
    logic [MODE_W-1:0]  mode_eff;
    logic               dl_wr_en;
    time_t              dl_wr_data;
    time_t              dl_rd_data;
    slot_t              rd_addr;

    logic [FORK_PROD_W-1:0] fork_prod;
    logic                   fork_ok;
    logic                   accept;
    logic                   out_free;
    logic                   wakes;

    assign in_opcode   = s_tdata[OPCODE_W-1:0];
    assign in_duration = s_tdata[OPCODE_W+DURATION_W-1:OPCODE_W];
    assign in_now      = s_tdata[S_DATA_BITS-1:OPCODE_W+DURATION_W];
    assign in_now_t    = TIME_BITS'(in_now);

    assign fork_prod = FORK_PROD_W'(NUM_SLOTS) * FORK_PROD_W'(stack_size_reg);
    assign fork_ok   = fork_prod <= FORK_PROD_W'(FORK_MEM_LIMIT);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign mode_eff = mode_valid_reg[eval_slot_reg] ? mode_rd_data : MODE_EMPTY;
    assign wakes    = (mode_eff == MODE_SLEEP) && (dl_rd_data < now_reg);

    rrts_ram #(
        .WIDTH (MODE_W),
        .DEPTH (NUM_SLOTS)
    ) u_mode_ram (
        .clk     (clk),
        .wr_en   (mode_wr_en),
        .wr_addr (mode_wr_addr),
        .wr_data (mode_wr_data),
        .rd_addr (rd_addr),
        .rd_data (mode_rd_data)
    );

    rrts_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (NUM_SLOTS)
    ) u_deadline_ram (
        .clk     (clk),
        .wr_en   (dl_wr_en),
        .wr_addr (active_reg),
        .wr_data (dl_wr_data),
        .rd_addr (rd_addr),
        .rd_data (dl_rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        active_next    = active_reg;
        eval_slot_next = eval_slot_reg;
        eval_cnt_next  = eval_cnt_reg;
        now_next       = now_reg;
        status_next    = status_reg;
        created_next   = created_reg;
        mode_wr_en     = 1'b0;
        mode_wr_addr   = active_reg;
        mode_wr_data   = MODE_EMPTY;
        dl_wr_en       = 1'b0;
        dl_wr_data     = in_now_t + TIME_BITS'(in_duration);
        rd_addr        = next_slot(eval_slot_reg);
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;

        case (state_reg)
            ST_IDLE:
            begin
                status_next  = ST_OK;
                created_next = '0;
                now_next     = in_now_t;
                rd_addr      = next_slot(active_reg);
                if (accept)
                begin
                    state_next = ST_DONE;
                    case (in_opcode)
                        OP_INIT:
                        begin
                            active_next  = '0;
                            mode_wr_en   = 1'b1;
                            mode_wr_addr = '0;
                            mode_wr_data = MODE_READY;
                        end
                        OP_TICK:
                        begin
                            eval_slot_next = next_slot(active_reg);
                            eval_cnt_next  = '0;
                            state_next     = ST_TICK;
                        end
                        OP_EXIT:
                        begin
                            mode_wr_en   = 1'b1;
                            mode_wr_data = MODE_EMPTY;
                        end
                        OP_SLEEP:
                        begin
                            mode_wr_en   = 1'b1;
                            mode_wr_data = MODE_SLEEP;
                            dl_wr_en     = 1'b1;
                        end
                        OP_SPAWN:
                        begin
                            active_next  = next_slot(active_reg);
                            created_next = next_slot(active_reg);
                            mode_wr_en   = 1'b1;
                            mode_wr_addr = next_slot(active_reg);
                            mode_wr_data = MODE_READY;
                        end
                        OP_FORK:
                        begin
                            if (fork_ok)
                            begin
                                active_next  = next_slot(active_reg);
                                created_next = next_slot(active_reg);
                                mode_wr_en   = 1'b1;
                                mode_wr_addr = next_slot(active_reg);
                                mode_wr_data = MODE_READY;
                            end
                            else
                            begin
                                status_next = ST_FORK_REFUSED;
                            end
                        end
                        OP_WAKE_ALL:
                        begin
                            rd_addr        = '0;
                            eval_slot_next = '0;
                            state_next     = ST_WAKE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_TICK:
            begin
                if ((mode_eff == MODE_READY) || wakes)
                begin
                    mode_wr_en   = wakes;
                    mode_wr_addr = eval_slot_reg;
                    mode_wr_data = MODE_READY;
                    active_next  = eval_slot_reg;
                    state_next   = ST_DONE;
                end
                else if (eval_cnt_reg == SLOT_W'(NUM_SLOTS - 1))
                begin
                    status_next = ST_NONE_READY;
                    state_next  = ST_DONE;
                end
                else
                begin
                    eval_slot_next = next_slot(eval_slot_reg);
                    eval_cnt_next  = eval_cnt_reg + SLOT_W'(1);
                end
            end
            ST_WAKE:
            begin
                mode_wr_en   = (mode_eff == MODE_SLEEP);
                mode_wr_addr = eval_slot_reg;
                mode_wr_data = MODE_READY;
                if (eval_slot_reg == SLOT_W'(NUM_SLOTS - 1))
                    state_next = ST_DONE;
                else
                    eval_slot_next = eval_slot_reg + SLOT_W'(1);
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = M_DATA_W'({out_slot(created_reg), status_reg,
                                              out_slot(active_reg)});
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            stack_size_reg <= STACK_SIZE_RESET;
            active_reg     <= '0;
            mode_valid_reg <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            active_reg  <= active_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en)
            begin
                stack_size_reg <= cfg_wr_data;
            end
            if (mode_wr_en)
            begin
                mode_valid_reg[mode_wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        eval_slot_reg <= eval_slot_next;
        eval_cnt_reg  <= eval_cnt_next;
        now_reg       <= now_next;
        status_reg    <= status_next;
        created_reg   <= created_next;
        m_data_reg    <= m_data_next;
    end

    a_wake_writes_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WAKE && mode_wr_en) |-> mode_wr_data == MODE_READY)
        else $error("wake-all sweep wrote a mode other than ready");

    a_tick_enters_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_opcode == OP_TICK) |=> state_reg == ST_TICK)
        else $error("accepted tick did not start the slot walk");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result word loaded outside the done state");

    a_tick_moves_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TICK && mode_wr_en) |=> active_reg == $past(eval_slot_reg))
        else $error("woken slot did not become the active slot");

endmodule

// File: src/rrts_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module rrts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
